>>> sv/polyphonic_sine_tone_mixer_macros.svh
// Assertion helpers for the mixer, clocked on aclk and off while aresetn is low.
`ifndef POLYPHONIC_SINE_TONE_MIXER_MACROS_SVH
`define POLYPHONIC_SINE_TONE_MIXER_MACROS_SVH

// Same-cycle implication
`define PSTM_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication
`define PSTM_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> sv/pstm_pkg.sv
`default_nettype none
package pstm_pkg;

    // Voice and table geometry
    localparam int VOICES         = 8;
    localparam int SINE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS    = 16;
    localparam int VIDX_W         = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VSHIFT         = (VOICES > 1) ? $clog2(VOICES) : 0;
    localparam int QUARTER        = 1 << (SINE_ADDR_BITS - 2);
    localparam int QIDX_W         = SINE_ADDR_BITS - 1;
    localparam int AMP_W          = SAMPLE_BITS - 1;
    localparam int ACC_W          = SAMPLE_BITS + VSHIFT;

    // Field widths
    localparam int OP_W      = 2;
    localparam int STEP_W    = 32;
    localparam int PHASE_W   = 32;
    localparam int SAMPLE_W  = 16;
    localparam int STATUS_W  = 3;
    localparam int INDEX_W   = 3;
    localparam int S_TDATA_W = ((STEP_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SAMPLE_W + INDEX_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_SAMPLE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STARTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // Fixed-point constants for the table build
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

    typedef logic [AMP_W-1:0] qsine_t [QUARTER+1];

    // Shift-and-subtract quotient, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(A * sin(2*pi*k/N)) by Taylor series in Q30, elaboration only
    function automatic logic [AMP_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0]        amp;
        logic [63:0]        t;
        logic [63:0]        term;
        logic [63:0]        dv;
        logic [63:0]        scaled;
        logic signed [63:0] sum;
        amp  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        t    = (64'(k) * TWO_PI_Q30) >> SINE_ADDR_BITS;
        term = t;
        sum  = signed'(t);
        for (int n = 1; n <= 6; n++) begin
            term = (term * t) >> 30;
            term = (term * t) >> 30;
            dv   = 64'(2 * n) * 64'(2 * n + 1);
            term = udiv64(term, dv);
            if ((n & 1) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        scaled = (unsigned'(sum) * amp + (ONE_Q30 >> 1)) >> 30;
        if (scaled > amp) begin
            scaled = amp;
        end
        return AMP_W'(scaled);
    endfunction

    function automatic qsine_t build_qsine();
        qsine_t tab;
        for (int i = 0; i <= QUARTER; i++) begin
            tab[i] = quarter_sine(i);
        end
        return tab;
    endfunction

    // Quarter-wave table, entries 0 .. QUARTER inclusive
    localparam qsine_t QSINE = build_qsine();

endpackage
`default_nettype wire

>>> sv/pstm_sine_lookup.sv
`default_nettype none
// Full-wave sine from the quarter-wave table by quadrant folding.
module pstm_sine_lookup
    import pstm_pkg::*;
(
    input  wire  logic        [SINE_ADDR_BITS-1:0] addr,
    output logic signed [SAMPLE_BITS-1:0]          value
);

    logic [1:0]              quad;
    logic [QIDX_W-1:0]       ofs;
    logic [QIDX_W-1:0]       k;
    logic [AMP_W-1:0]        mag;

    // Mirror in odd quadrants, negate in the second half cycle
    always_comb begin
        quad  = addr[SINE_ADDR_BITS-1 -: 2];
        ofs   = QIDX_W'(addr[SINE_ADDR_BITS-3:0]);
        k     = quad[0] ? (QIDX_W'(QUARTER) - ofs) : ofs;
        mag   = QSINE[k];
        value = quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end

endmodule
`default_nettype wire

>>> sv/polyphonic_sine_tone_mixer.sv
`default_nettype none
// Sample word: S_RUN scans all VOICES voices through the one shared sine lookup, then
// S_DONE loads the output register once it is free, and m_tvalid rises. A new word is
// accepted only back in S_IDLE, after the result has been handed to the output register.
// Start/stop words scan until the first free or matching voice, then go to S_DONE.
// Synchronous active-low reset frees all voices, zeroes phases and empties the output.
`include "polyphonic_sine_tone_mixer_macros.svh"
module polyphonic_sine_tone_mixer
    import pstm_pkg::*;
(
    input  wire  logic                 aclk,
    input  wire  logic                 aresetn,
    input  wire  logic                 s_tvalid,
    output logic                       s_tready,
    input  wire  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] phase_step
    input  wire  logic [OP_W-1:0]      s_tuser,   // [1:0] operation
    output logic                       m_tvalid,
    input  wire  logic                 m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [15:0] sample, [18:16] voice_index
    output logic [STATUS_W-1:0]        m_tuser    // [2:0] status
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

    state_t                    state_reg,  state_next;
    logic [OP_W-1:0]           op_reg,     op_next;
    logic [STEP_W-1:0]         step_reg,   step_next;
    logic [VIDX_W-1:0]         idx_reg,    idx_next;
    logic signed [ACC_W-1:0]   acc_reg,    acc_next;
    logic [VOICES-1:0]         active_reg, active_next;
    logic [STEP_W-1:0]         vstep_reg  [VOICES];
    logic [STEP_W-1:0]         vstep_next [VOICES];
    logic [PHASE_W-1:0]        phase_reg  [VOICES];
    logic [PHASE_W-1:0]        phase_next [VOICES];
    logic [SAMPLE_W-1:0]       rsample_reg, rsample_next;
    logic [STATUS_W-1:0]       rstatus_reg, rstatus_next;
    logic [INDEX_W-1:0]        rindex_reg,  rindex_next;
    logic                      mvalid_reg,  mvalid_next;
    logic [SAMPLE_W-1:0]       msample_reg, msample_next;
    logic [STATUS_W-1:0]       mstatus_reg, mstatus_next;
    logic [INDEX_W-1:0]        mindex_reg,  mindex_next;

    logic                      last_voice;
    logic signed [SAMPLE_BITS-1:0] sine_val;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_shifted;

    // Shared sine lookup, addressed by the current voice's phase
    pstm_sine_lookup u_sine (
        .addr  (phase_reg[idx_reg][PHASE_W-1 -: SINE_ADDR_BITS]),
        .value (sine_val)
    );

    assign last_voice  = (idx_reg == VIDX_W'(VOICES - 1));
    assign acc_sum     = acc_reg + ACC_W'(sine_val);
    assign acc_shifted = acc_sum >>> VSHIFT;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tuser  = mstatus_reg;
    assign m_tdata  = M_TDATA_W'({mindex_reg, msample_reg});

    // Sequencer: one voice per cycle through the shared unit
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        active_next  = active_reg;
        vstep_next   = vstep_reg;
        phase_next   = phase_reg;
        rsample_next = rsample_reg;
        rstatus_next = rstatus_reg;
        rindex_next  = rindex_reg;
        mvalid_next  = mvalid_reg;
        msample_next = msample_reg;
        mstatus_next = mstatus_reg;
        mindex_next  = mindex_reg;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    step_next  = s_tdata[STEP_W-1:0];
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                idx_next = idx_reg + VIDX_W'(1);
                case (op_reg)
                    OP_SAMPLE: begin
                        if (active_reg[idx_reg]) begin
                            acc_next            = acc_sum;
                            phase_next[idx_reg] = phase_reg[idx_reg] + vstep_reg[idx_reg];
                        end
                        if (last_voice) begin
                            rsample_next = active_reg[idx_reg] ? SAMPLE_W'(acc_shifted)
                                                               : SAMPLE_W'(acc_reg >>> VSHIFT);
                            rstatus_next = ST_SAMPLE;
                            rindex_next  = '0;
                            state_next   = S_DONE;
                        end
                    end
                    OP_START: begin
                        if (!active_reg[idx_reg]) begin
                            active_next[idx_reg] = 1'b1;
                            vstep_next[idx_reg]  = step_reg;
                            phase_next[idx_reg]  = '0;
                            rsample_next         = '0;
                            rstatus_next         = ST_STARTED;
                            rindex_next          = INDEX_W'(idx_reg);
                            state_next           = S_DONE;
                        end else if (last_voice) begin
                            rsample_next = '0;
                            rstatus_next = ST_NO_FREE;
                            rindex_next  = '0;
                            state_next   = S_DONE;
                        end
                    end
                    OP_STOP: begin
                        if (active_reg[idx_reg] && (vstep_reg[idx_reg] == step_reg)) begin
                            active_next[idx_reg] = 1'b0;
                            rsample_next         = '0;
                            rstatus_next         = ST_STOPPED;
                            rindex_next          = INDEX_W'(idx_reg);
                            state_next           = S_DONE;
                        end else if (last_voice) begin
                            rsample_next = '0;
                            rstatus_next = ST_NOT_FOUND;
                            rindex_next  = '0;
                            state_next   = S_DONE;
                        end
                    end
                    default: begin
                        // unused operation: dropped, no result
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DONE: begin
                // hand the result to the output register once it is free
                if (!mvalid_reg || m_tready) begin
                    mvalid_next  = 1'b1;
                    msample_next = rsample_reg;
                    mstatus_next = rstatus_reg;
                    mindex_next  = rindex_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
            active_reg <= '0;
            for (int i = 0; i < VOICES; i++) begin
                phase_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            active_reg <= active_next;
            phase_reg  <= phase_next;
        end
        op_reg      <= op_next;
        step_reg    <= step_next;
        idx_reg     <= idx_next;
        acc_reg     <= acc_next;
        vstep_reg   <= vstep_next;
        rsample_reg <= rsample_next;
        rstatus_reg <= rstatus_next;
        rindex_reg  <= rindex_next;
        msample_reg <= msample_next;
        mstatus_reg <= mstatus_next;
        mindex_reg  <= mindex_next;
    end

    // Checks
    `PSTM_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")
    `PSTM_ASSERT_IMP(a_sample_no_index, m_tvalid && (m_tuser == ST_SAMPLE), m_tdata[SAMPLE_W +: INDEX_W] == '0, "sample word carries a voice index")
    `PSTM_ASSERT_IMP(a_fail_zero, m_tvalid && (m_tuser == ST_NO_FREE || m_tuser == ST_NOT_FOUND), m_tdata[SAMPLE_W+INDEX_W-1:0] == '0, "failed note word not zero")

endmodule
`default_nettype wire
